// ===== rtl/hlr_pkg.sv =====
package hlr_pkg;

    localparam int MAX_BARS_D    = 1024;
    localparam int HEIGHT_BITS_D = 16;
    localparam int IN_H_W        = 16;
    localparam int AREA_W        = 26;

    typedef struct packed {
        logic [IN_H_W-1:0] bar_height;
        logic              last_bar;
    } t_in_item;

    typedef struct packed {
        logic [AREA_W-1:0] max_area;
        logic              overflowed;
    } t_out_item;

    // Command from the sequencer to the multiply-compare unit
    typedef struct packed {
        logic start;
        logic clear;
    } t_mac_ctrl;

endpackage

// ===== rtl/histogram_largest_rectangle.sv =====
// Channel | Signals                              | Direction
// in      | i_in_valid, o_in_ready, i_in_data    | bars in
// out     | o_out_valid, i_out_ready, o_out_data | area result out
//
// Bars load one per cycle into the height memory while o_in_ready is high.
// The last bar starts a monotonic-stack scan: each bar costs a fetch and a
// test, the zero sentinel past the end costs a fetch and a test as well, and
// each pop takes a test, memory reads and a multiply; the scan then passes
// through S_DRAIN1, S_DRAIN2 and S_OUT before the result is valid.
// Synchronous active-low reset clears control; memories need no clearing.
// The result waits in an output register until taken; input stays stalled.
module histogram_largest_rectangle #(
    parameter int MAX_BARS    = hlr_pkg::MAX_BARS_D,
    parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hlr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hlr_pkg::t_out_item o_out_data
);
    import hlr_pkg::*;

    localparam int IW = $clog2(MAX_BARS);
    localparam int CW = IW + 1;
    localparam int PW = HEIGHT_BITS + CW;

    typedef enum logic [7:0] {
        S_LOAD   = 8'b0000_0001,
        S_FETCH  = 8'b0000_0010,
        S_TEST   = 8'b0000_0100,
        S_POPRD  = 8'b0000_1000,
        S_POPMUL = 8'b0001_0000,
        S_DRAIN1 = 8'b0010_0000,
        S_DRAIN2 = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [HEIGHT_BITS-1:0] r_heights [MAX_BARS];
    logic [IW-1:0]          r_stack   [MAX_BARS];

    logic [CW-1:0]          r_count;
    logic                   r_ovf;
    logic [CW-1:0]          r_i;
    logic [CW-1:0]          r_depth;
    logic [HEIGHT_BITS-1:0] r_cur_h;
    logic [IW-1:0]          r_top_idx;
    logic [IW-1:0]          r_below_idx;
    logic [HEIGHT_BITS-1:0] r_top_h;
    logic [HEIGHT_BITS-1:0] r_rd_h;
    logic [HEIGHT_BITS-1:0] r_mul_h;
    logic [CW-1:0]          r_mul_w;
    t_out_item              r_out;
    logic                   r_out_vld;

    t_mac_ctrl              mac;
    logic [PW-1:0]          best;

    wire in_xfer  = i_in_valid && o_in_ready;
    wire out_xfer = o_out_valid && i_out_ready;
    wire full     = (r_count == CW'(MAX_BARS));

    // Entry below the stack top, read registered
    logic [IW-1:0] r_st_below;
    always_ff @(posedge i_clk) begin
        r_st_below <= r_stack[IW'(r_depth - CW'(2))];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:   if (in_xfer && i_in_data.last_bar) n_state = S_FETCH;
            S_FETCH:  n_state = S_TEST;
            S_TEST: begin
                if (r_depth != '0 && r_top_h >= r_cur_h) n_state = S_POPRD;
                else if (r_i == r_count)                 n_state = S_DRAIN1;
                else                                     n_state = S_FETCH;
            end
            S_POPRD:  n_state = S_POPMUL;
            S_POPMUL: n_state = S_TEST;
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_OUT;
            S_OUT:    if (out_xfer) n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
    end

    assign mac.start = (r_state == S_POPMUL);
    assign mac.clear = (r_state == S_OUT) && out_xfer;

    hlr_area_unit #(.HEIGHT_BITS(HEIGHT_BITS), .WIDTH_BITS(CW)) u_area (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac),
        .i_height (r_mul_h),
        .i_width  (r_mul_w),
        .o_best   (best)
    );

    // Memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && in_xfer && !full) begin
            r_heights[IW'(r_count)] <= i_in_data.bar_height[HEIGHT_BITS-1:0];
        end
        if (r_state == S_TEST && !(r_depth != '0 && r_top_h >= r_cur_h)
            && r_i != r_count) begin
            r_stack[IW'(r_depth)] <= IW'(r_i);
        end
        r_rd_h <= r_heights[r_below_idx];
        // Current bar height; zero sentinel past the end
        if (r_state == S_FETCH) begin
            r_cur_h <= (r_i == r_count) ? '0 : r_heights[IW'(r_i)];
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_i       <= '0;
            r_depth   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (full) r_ovf <= 1'b1;
                        else      r_count <= r_count + CW'(1);
                    end
                    r_i     <= '0;
                    r_depth <= '0;
                end
                S_FETCH: begin
                    // height memory read lands next cycle
                end
                S_TEST: begin
                    if (r_depth != '0 && r_top_h >= r_cur_h) begin
                        r_mul_h <= r_top_h;
                        r_depth <= r_depth - CW'(1);
                        if (r_depth == CW'(1)) r_mul_w <= r_i;
                        else r_mul_w <= r_i - CW'(r_below_idx) - CW'(1);
                    end else if (r_i != r_count) begin
                        r_top_idx <= IW'(r_i);
                        r_top_h   <= r_cur_h;
                        r_below_idx <= r_top_idx;
                        r_depth   <= r_depth + CW'(1);
                        r_i       <= r_i + CW'(1);
                    end
                end
                S_POPRD: begin
                    r_top_idx <= r_below_idx;
                end
                S_POPMUL: begin
                    r_top_h     <= r_rd_h;
                    r_below_idx <= r_st_below;
                end
                S_DRAIN1, S_DRAIN2: begin
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_out_vld <= 1'b0;
                        r_count   <= '0;
                        r_ovf     <= 1'b0;
                    end else begin
                        r_out_vld <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        r_out.overflowed <= r_ovf;
        r_out.max_area   <= (best > PW'({AREA_W{1'b1}})) ? {AREA_W{1'b1}}
                                                         : AREA_W'(best);
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_vld && (r_state == S_OUT);
    assign o_out_data  = r_out;

    // Never accept and emit together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output both active");

    // Stack depth never exceeds bars scanned
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_i)
        else $error("stack deeper than scan index");

    // Bar count stays within capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BARS))
        else $error("bar count beyond capacity");

endmodule

// ===== rtl/hlr_area_unit.sv =====
module hlr_area_unit #(
    parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_D,
    parameter int WIDTH_BITS  = 11
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  hlr_pkg::t_mac_ctrl                      i_ctrl,
    input  logic [HEIGHT_BITS-1:0]                  i_height,
    input  logic [WIDTH_BITS-1:0]                   i_width,
    output logic [HEIGHT_BITS+WIDTH_BITS-1:0]       o_best
);
    import hlr_pkg::*;

    localparam int PW = HEIGHT_BITS + WIDTH_BITS;

    logic [PW-1:0] r_prod;
    logic          r_prod_vld;
    logic [PW-1:0] r_best;

    // Registered multiply, then compare against the running maximum in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_best     <= '0;
        end else begin
            r_prod_vld <= i_ctrl.start;
            if (i_ctrl.clear) begin
                r_best <= '0;
            end else if (r_prod_vld && r_prod > r_best) begin
                r_best <= r_prod;
            end
        end
        r_prod <= PW'(i_height) * PW'(i_width);
    end

    assign o_best = r_best;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hlr_pkg::*;

    localparam int NBARS    = MAX_BARS_D;
    localparam int HMASK    = (1 << HEIGHT_BITS_D) - 1;
    localparam int CYC_MAX  = 3000000;
    localparam int N_RANDOM = 560;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    histogram_largest_rectangle u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predictor state
    int unsigned bar_store[NBARS];
    int unsigned stored_bars = 0;
    bit          bars_dropped = 0;

    t_in_item  bar_queue[$];
    t_out_item area_queue[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        hold_off;

    // Largest area under the stored bars, monotonic stack
    function automatic longint unsigned scan_area(int unsigned n);
        int unsigned      stk[NBARS];
        int unsigned      depth;
        longint unsigned  best;
        longint unsigned  h;
        longint unsigned  top_h;
        longint unsigned  w;
        best  = 0;
        depth = 0;
        for (int unsigned i = 0; i <= n; i++) begin
            h = (i < n) ? bar_store[i] : 0;
            while (depth > 0 && bar_store[stk[depth-1]] >= h) begin
                top_h = bar_store[stk[depth-1]];
                depth--;
                w = (depth == 0) ? i : (i - stk[depth-1] - 1);
                if (top_h * w > best) best = top_h * w;
            end
            if (i < n) begin
                stk[depth] = i;
                depth++;
            end
        end
        return best;
    endfunction

    // Apply one accepted bar to the predictor
    task automatic predict_bar(input t_in_item it);
        longint unsigned a;
        t_out_item       r;
        if (stored_bars < NBARS) begin
            bar_store[stored_bars] = it.bar_height & HMASK;
            stored_bars++;
        end else begin
            bars_dropped = 1;
        end
        if (it.last_bar) begin
            a = scan_area(stored_bars);
            r.max_area   = (a > 64'h3FF_FFFF) ? '1 : a[AREA_W-1:0];
            r.overflowed = bars_dropped;
            area_queue.push_back(r);
            stored_bars  = 0;
            bars_dropped = 0;
        end
    endtask

    task automatic add_bar(input int unsigned h, input bit last);
        t_in_item it;
        it.bar_height = h[IN_H_W-1:0];
        it.last_bar   = last;
        bar_queue.push_back(it);
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic int unsigned rand_height();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(0, 7);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            in_gap     <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold until transfer
        end else begin
            if (i_in_valid) predict_bar(i_in_data);
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (bar_queue.size() > 0) begin
                i_in_data  <= bar_queue.pop_front();
                i_in_valid <= 1'b1;
                in_gap     <= gap_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with random stalls and one long hold-off
    int out_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
        end else if (hold_off) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_gap     <= gap_len();
        end
    end

    // Long receiver hold-off while bars keep coming
    initial begin
        hold_off = 1'b0;
        wait (i_rst_n === 1'b1);
        wait (bar_queue.size() < 800);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Monitor
    t_out_item want;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (area_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = area_queue.pop_front();
                if (want.max_area !== o_out_data.max_area ||
                        want.overflowed !== o_out_data.overflowed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp area %0d ovf %0b, got area %0d ovf %0b",
                                 want.max_area, want.overflowed,
                                 o_out_data.max_area, o_out_data.overflowed);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        if (cycles > CYC_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus
    int n_items;
    int len;
    initial begin
        i_rst_n = 1'b0;

        // Directed: single bars at extremes, zero, tie, descending
        add_bar(0, 1);
        add_bar(16'hFFFF, 1);
        add_bar(16'hFFFF, 0); add_bar(16'hFFFF, 1);
        add_bar(3, 0); add_bar(3, 0); add_bar(3, 1);
        add_bar(5, 0); add_bar(4, 0); add_bar(1, 0); add_bar(6, 1);
        add_bar(2, 0); add_bar(1, 0); add_bar(5, 0); add_bar(6, 0);
        add_bar(2, 0); add_bar(3, 1);
        add_bar(16'hAAAA, 0); add_bar(16'h5555, 1);
        // Full histogram of tallest bars, then extra bars that are dropped
        for (int i = 0; i < NBARS + 3; i++)
            add_bar((i < NBARS) ? 16'hFFFF : (i & 16'hFF), i == NBARS + 2);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random histograms, mostly short
        n_items = 0;
        while (n_items < N_RANDOM) begin
            len = ($urandom_range(0, 30) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) add_bar(rand_height(), i == len - 1);
            n_items += len;
        end

        wait (bar_queue.size() == 0 && !i_in_valid);
        wait (area_queue.size() == 0);
        repeat (4 * NBARS + 50) @(posedge i_clk);
        if (mismatches == 0 && area_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
